@@ rtl/core/four_key_short_long_press_mode_defines.svh @@
`ifndef FOUR_KEY_SHORT_LONG_PRESS_MODE_DEFINES_SVH
`define FOUR_KEY_SHORT_LONG_PRESS_MODE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FKP_ASSERT_NOW(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FKP_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/fkp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package fkp_pkg;

    localparam int COUNT_WIDTH  = 16;
    localparam int THRESH_WIDTH = 16;
    localparam int CMP_WIDTH    = (COUNT_WIDTH > THRESH_WIDTH) ? COUNT_WIDTH : THRESH_WIDTH;
    localparam int CFG_INDEX_WIDTH = 1;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    localparam logic [THRESH_WIDTH-1:0] DEBOUNCE_RESET = THRESH_WIDTH'(500);
    localparam logic [THRESH_WIDTH-1:0] LONG_RESET     = THRESH_WIDTH'(10000);
    localparam logic [7:0]              MODE_RESET     = 8'h02;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_LONG     = 1'b1;

    // Press kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_SHORT = 2'd1;
    localparam logic [1:0] KIND_LONG  = 2'd2;

    // Key indexes, highest priority first
    localparam logic [1:0] KEY_SYSTEM = 2'd0;
    localparam logic [1:0] KEY_MOTOR  = 2'd1;
    localparam logic [1:0] KEY_STEER  = 2'd2;
    localparam logic [1:0] KEY_LIGHT  = 2'd3;

    typedef struct packed {
        logic [7:0] mode_bits;
        logic [1:0] press_kind;
        logic [1:0] press_key;
    } result_t;

    // Set the pressed key's bit and drop its partner bit; the steer key only sets.
    function automatic logic [7:0] mode_update(input logic [7:0] mode,
                                               input logic [1:0] key,
                                               input logic       is_long);
        logic [7:0] set_mask;
        logic [7:0] keep_mask;
        begin
            case (key)
                KEY_SYSTEM:
                begin
                    set_mask  = is_long ? 8'h80 : 8'h40;
                    keep_mask = is_long ? 8'hBF : 8'h7F;
                end
                KEY_MOTOR:
                begin
                    set_mask  = is_long ? 8'h20 : 8'h10;
                    keep_mask = is_long ? 8'hEF : 8'hDF;
                end
                KEY_STEER:
                begin
                    set_mask  = is_long ? 8'h08 : 8'h04;
                    keep_mask = 8'hFF;
                end
                default:
                begin
                    set_mask  = is_long ? 8'h02 : 8'h01;
                    keep_mask = is_long ? 8'hFE : 8'hFD;
                end
            endcase
            mode_update = (mode | set_mask) & keep_mask;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/fkp_press_fsm.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "four_key_short_long_press_mode_defines.svh"

module fkp_press_fsm (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  accept,
    input  wire logic [3:0]                            key_levels,
    input  wire logic                                  cfg_we,
    input  wire logic [fkp_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [fkp_pkg::THRESH_WIDTH-1:0]      cfg_data,
    output fkp_pkg::result_t                           result
);

    typedef enum logic [1:0] {PH_IDLE, PH_DEBOUNCE, PH_HOLD, PH_WAIT} phase_t;

    phase_t                               phase_reg, phase_next;
    logic [1:0]                           active_key_reg, active_key_next;
    logic [fkp_pkg::COUNT_WIDTH-1:0]      tick_count_reg, tick_count_next;
    logic [7:0]                           mode_reg, mode_next;
    logic [fkp_pkg::THRESH_WIDTH-1:0]     debounce_reg;
    logic [fkp_pkg::THRESH_WIDTH-1:0]     long_reg;

    logic                                 held;
    logic [1:0]                           first_key;
    logic [fkp_pkg::COUNT_WIDTH-1:0]      count_inc;
    logic                                 debounce_done;
    logic                                 long_done;
    logic [1:0]                           kind;

    assign held = key_levels[active_key_reg];

    always_comb
    begin
        if (key_levels[0])
            first_key = fkp_pkg::KEY_SYSTEM;
        else if (key_levels[1])
            first_key = fkp_pkg::KEY_MOTOR;
        else if (key_levels[2])
            first_key = fkp_pkg::KEY_STEER;
        else
            first_key = fkp_pkg::KEY_LIGHT;
    end

    // Saturate the tick counter at its maximum.
    assign count_inc = (tick_count_reg == fkp_pkg::CNT_MAX) ? tick_count_reg
                                                             : tick_count_reg + 1'b1;

    assign debounce_done = fkp_pkg::CMP_WIDTH'(count_inc) >= fkp_pkg::CMP_WIDTH'(debounce_reg);
    assign long_done     = fkp_pkg::CMP_WIDTH'(count_inc) >= fkp_pkg::CMP_WIDTH'(long_reg);

    always_comb
    begin
        phase_next      = phase_reg;
        active_key_next = active_key_reg;
        tick_count_next = tick_count_reg;
        kind            = fkp_pkg::KIND_NONE;
        case (phase_reg)
            PH_IDLE:
            begin
                if (key_levels != 4'd0)
                begin
                    active_key_next = first_key;
                    tick_count_next = '0;
                    phase_next      = PH_DEBOUNCE;
                end
            end
            PH_DEBOUNCE:
            begin
                tick_count_next = count_inc;
                if (debounce_done)
                begin
                    if (held)
                    begin
                        tick_count_next = '0;
                        phase_next      = PH_HOLD;
                    end
                    else
                    begin
                        kind       = fkp_pkg::KIND_SHORT;
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_HOLD:
            begin
                if (held)
                begin
                    tick_count_next = count_inc;
                    if (long_done)
                    begin
                        kind       = fkp_pkg::KIND_LONG;
                        phase_next = PH_WAIT;
                    end
                end
                else
                begin
                    kind       = fkp_pkg::KIND_SHORT;
                    phase_next = PH_IDLE;
                end
            end
            PH_WAIT:
            begin
                if (!held)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    assign mode_next = (kind == fkp_pkg::KIND_NONE) ? mode_reg
                     : fkp_pkg::mode_update(mode_reg, active_key_reg,
                                            kind == fkp_pkg::KIND_LONG);

    assign result.mode_bits  = mode_next;
    assign result.press_kind = kind;
    assign result.press_key  = (kind == fkp_pkg::KIND_NONE) ? 2'd0 : active_key_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            active_key_reg <= 2'd0;
            tick_count_reg <= '0;
            mode_reg       <= fkp_pkg::MODE_RESET;
            debounce_reg   <= fkp_pkg::DEBOUNCE_RESET;
            long_reg       <= fkp_pkg::LONG_RESET;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                active_key_reg <= active_key_next;
                tick_count_reg <= tick_count_next;
                mode_reg       <= mode_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    fkp_pkg::REG_DEBOUNCE: debounce_reg <= cfg_data;
                    fkp_pkg::REG_LONG:     long_reg     <= cfg_data;
                    default:               debounce_reg <= debounce_reg;
                endcase
            end
        end
    end

    `FKP_ASSERT_NOW(a_idle_no_press, clk, rst_n, phase_reg == PH_IDLE, kind == fkp_pkg::KIND_NONE, "press recorded while idle")
    `FKP_ASSERT_NEXT(a_long_then_wait, clk, rst_n, accept && kind == fkp_pkg::KIND_LONG, phase_reg == PH_WAIT, "long press did not enter release wait")
    `FKP_ASSERT_NEXT(a_mode_holds, clk, rst_n, !accept, $stable(mode_reg) && $stable(phase_reg), "state moved without a beat")

endmodule

`default_nettype wire

@@ rtl/core/fkp_out_buffer.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "four_key_short_long_press_mode_defines.svh"

module fkp_out_buffer (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  fkp_pkg::result_t      push_data,
    output logic                  full,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output fkp_pkg::result_t      out_data
);

    fkp_pkg::result_t out_reg, out_next;
    fkp_pkg::result_t skid_reg, skid_next;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             out_fire;

    assign out_fire = out_valid_reg && !out_stall;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            // Input is stalled here; drain the skid entry into the output.
            if (out_fire)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || out_fire)
            begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `FKP_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid entry held with empty output")
    `FKP_ASSERT_NOW(a_no_push_when_full, clk, rst_n, skid_valid_reg, !push, "beat pushed into full buffer")
    `FKP_ASSERT_NEXT(a_out_held, clk, rst_n, out_valid_reg && out_stall, out_valid_reg && $stable(out_reg), "stalled beat changed")

endmodule

`default_nettype wire

@@ rtl/core/four_key_short_long_press_mode.sv @@
// Four-key short/long press detector driving an 8-bit mode register. Each
// input beat is one tick of the four key levels (bit0 system, bit1 motor,
// bit2 steer, bit3 light) and yields exactly one output beat carrying the
// mode register after that tick plus any short or long press recorded on it.
// The press state machine and tick counter update at the input beat and the
// result lands in an output register backed by a one-entry skid stage, so a
// new tick is taken every cycle while the output side keeps up. in_stall
// rises only when both output entries are full and clears the cycle after
// the consumer takes a beat. The debounce and long-press thresholds are
// counted in ticks and written through the cfg_we/cfg_index/cfg_data port
// (index 0 debounce_ticks, index 1 long_ticks); the user must write them only
// while no tick is in flight, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module four_key_short_long_press_mode (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [3:0]                            key_levels,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [7:0]                                 mode_bits,
    output logic [1:0]                                 press_kind,
    output logic [1:0]                                 press_key,
    input  wire logic                                  cfg_we,
    input  wire logic [fkp_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [fkp_pkg::THRESH_WIDTH-1:0]      cfg_data
);

    logic             in_accept;
    logic             buf_full;
    fkp_pkg::result_t tick_result;
    fkp_pkg::result_t out_data;

    // Take a tick whenever the output buffer has room.
    assign in_stall  = buf_full;
    assign in_accept = in_valid && !buf_full;

    fkp_press_fsm u_press_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (in_accept),
        .key_levels (key_levels),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .result     (tick_result)
    );

    // Hold results here until the consumer takes the beat.
    fkp_out_buffer u_out_buffer (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_accept),
        .push_data (tick_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign mode_bits  = out_data.mode_bits;
    assign press_kind = out_data.press_kind;
    assign press_key  = out_data.press_key;

endmodule

`default_nettype wire

@@ test/four_key_short_long_press_mode_tb.sv @@
`timescale 1ns / 1ps

module four_key_short_long_press_mode_tb;

    // Local view of the press state machine, used only by the predictor.
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_DEBOUNCE,
        PH_HOLD,
        PH_WAIT_RELEASE
    } press_phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [3:0] key_levels = 4'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] mode_bits;
    logic [1:0] press_kind;
    logic [1:0] press_key;
    logic                                  cfg_we = 1'b0;
    logic [fkp_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index = fkp_pkg::REG_DEBOUNCE;
    logic [fkp_pkg::THRESH_WIDTH-1:0]      cfg_data = '0;

    // Predicted state, mirrors the block's registers.
    press_phase_t                      press_phase = PH_IDLE;
    logic [1:0]                        key_latched = fkp_pkg::KEY_SYSTEM;
    logic [fkp_pkg::COUNT_WIDTH-1:0]   tick_cnt = '0;
    logic [7:0]                        mode_reg = fkp_pkg::MODE_RESET;
    logic [fkp_pkg::THRESH_WIDTH-1:0]  debounce_thr = fkp_pkg::DEBOUNCE_RESET;
    logic [fkp_pkg::THRESH_WIDTH-1:0]  long_thr = fkp_pkg::LONG_RESET;

    fkp_pkg::result_t pending_results[$];

    int fail_count = 0;
    int ticks_sent = 0;
    int hold_off_left = 0;  // receiver hold-off, counted down by the receiver
    bit steady = 1'b0;      // when set, neither side idles

    four_key_short_long_press_mode u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .key_levels (key_levels),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .mode_bits  (mode_bits),
        .press_kind (press_kind),
        .press_key  (press_key),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    // Set the pressed key's bit of its pair and drop the partner bit.
    // The steer key has no partner: it only ever sets.
    function automatic logic [7:0] apply_press(input logic [7:0] mode,
                                               input logic [1:0] key,
                                               input logic       is_long);
        logic [7:0] set_bit;
        logic [7:0] drop_bit;
        begin
            set_bit  = 8'h00;
            drop_bit = 8'h00;
            if (key == fkp_pkg::KEY_SYSTEM)
            begin
                set_bit  = is_long ? 8'h80 : 8'h40;
                drop_bit = is_long ? 8'h40 : 8'h80;
            end
            else if (key == fkp_pkg::KEY_MOTOR)
            begin
                set_bit  = is_long ? 8'h20 : 8'h10;
                drop_bit = is_long ? 8'h10 : 8'h20;
            end
            else if (key == fkp_pkg::KEY_STEER)
            begin
                set_bit  = is_long ? 8'h08 : 8'h04;
            end
            else
            begin
                set_bit  = is_long ? 8'h02 : 8'h01;
                drop_bit = is_long ? 8'h01 : 8'h02;
            end
            apply_press = (mode | set_bit) & ~drop_bit;
        end
    endfunction

    // Advance the predicted state by one tick and return the beat it yields.
    function automatic fkp_pkg::result_t advance_press_state(input logic [3:0] lv);
        fkp_pkg::result_t r;
        logic             held;
        logic [1:0]       kind;
        begin
            held = lv[key_latched];
            kind = fkp_pkg::KIND_NONE;
            case (press_phase)
                PH_IDLE:
                begin
                    if (lv != 4'd0)
                    begin
                        // Lowest set bit wins: system, motor, steer, light.
                        if (lv[0])
                            key_latched = fkp_pkg::KEY_SYSTEM;
                        else if (lv[1])
                            key_latched = fkp_pkg::KEY_MOTOR;
                        else if (lv[2])
                            key_latched = fkp_pkg::KEY_STEER;
                        else
                            key_latched = fkp_pkg::KEY_LIGHT;
                        tick_cnt    = '0;
                        press_phase = PH_DEBOUNCE;
                    end
                end
                PH_DEBOUNCE:
                begin
                    if (tick_cnt != fkp_pkg::CNT_MAX)
                        tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt >= debounce_thr)
                    begin
                        if (held)
                        begin
                            tick_cnt    = '0;
                            press_phase = PH_HOLD;
                        end
                        else
                        begin
                            kind        = fkp_pkg::KIND_SHORT;
                            press_phase = PH_IDLE;
                        end
                    end
                end
                PH_HOLD:
                begin
                    if (held)
                    begin
                        if (tick_cnt != fkp_pkg::CNT_MAX)
                            tick_cnt = tick_cnt + 1'b1;
                        if (tick_cnt >= long_thr)
                        begin
                            kind        = fkp_pkg::KIND_LONG;
                            press_phase = PH_WAIT_RELEASE;
                        end
                    end
                    else
                    begin
                        kind        = fkp_pkg::KIND_SHORT;
                        press_phase = PH_IDLE;
                    end
                end
                default:
                begin
                    // Release ends the wait; nothing is latched on this tick.
                    if (!held)
                        press_phase = PH_IDLE;
                end
            endcase
            if (kind != fkp_pkg::KIND_NONE)
                mode_reg = apply_press(mode_reg, key_latched, kind == fkp_pkg::KIND_LONG);
            r.mode_bits  = mode_reg;
            r.press_kind = kind;
            r.press_key  = (kind == fkp_pkg::KIND_NONE) ? 2'd0 : key_latched;
            advance_press_state = r;
        end
    endfunction

    // Offer one tick, wait for the beat to be taken, then predict its result.
    // Valid stays high on return; the caller either offers the next tick in
    // the same step or drops valid before letting time pass.
    task automatic send_tick(input logic [3:0] lv);
        begin
            while (!steady && $urandom_range(0, 99) < 17)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid   <= 1'b1;
            key_levels <= lv;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            pending_results.push_back(advance_press_state(lv));
            ticks_sent++;
        end
    endtask

    // Drop valid, let every expected beat drain, then let the output stage
    // settle.
    task automatic drain_results;
        begin
            in_valid <= 1'b0;
            while (pending_results.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [fkp_pkg::CFG_INDEX_WIDTH-1:0] idx,
                             input logic [fkp_pkg::THRESH_WIDTH-1:0]    val);
        begin
            drain_results();
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            cfg_we    <= 1'b0;
            if (idx == fkp_pkg::REG_DEBOUNCE)
                debounce_thr = val;
            else
                long_thr = val;
        end
    endtask

    // Mode register comes up at its reset value; idle ticks record nothing.
    // Run the reset debounce partway, then shorten it mid-debounce.
    task automatic test_reset_state;
        begin
            send_tick(4'b0000);
            send_tick(4'b0000);
            repeat (4) send_tick(4'b1000);
            write_reg(fkp_pkg::REG_DEBOUNCE, 16'd1);
            send_tick(4'b1000);   // reaches debounce, still held: go to hold
            send_tick(4'b0000);   // release in hold: short press of light
        end
    endtask

    // Short and long press of every key with both thresholds at one tick.
    task automatic test_each_key;
        logic [3:0] lv;
        int         k;
        begin
            write_reg(fkp_pkg::REG_DEBOUNCE, 16'd1);
            write_reg(fkp_pkg::REG_LONG, 16'd1);
            for (k = 0; k < 4; k++)
            begin
                lv = 4'd1 << k;
                send_tick(lv);
                send_tick(lv);
                send_tick(4'b0000);
                send_tick(lv);
                send_tick(lv);
                send_tick(lv);
                send_tick(4'b0000);
            end
        end
    endtask

    // Zero thresholds, priority among several keys, release with another key
    // down during the release wait, and release during debounce.
    task automatic test_zero_thresholds;
        begin
            write_reg(fkp_pkg::REG_DEBOUNCE, 16'd0);
            write_reg(fkp_pkg::REG_LONG, 16'd0);
            send_tick(4'b1111);   // system wins
            send_tick(4'b0001);
            send_tick(4'b0001);   // first held tick is already long
            send_tick(4'b1110);   // release: back to idle, motor not latched
            send_tick(4'b0110);   // motor latched now
            send_tick(4'b0000);   // gone at the debounce sample: short press
        end
    endtask

    // Largest thresholds: a long press can never be reached in practice, and
    // the longest debounce is cut short by a write mid-debounce.
    task automatic test_max_thresholds;
        begin
            write_reg(fkp_pkg::REG_DEBOUNCE, 16'd1);
            write_reg(fkp_pkg::REG_LONG, 16'hFFFF);
            repeat (4) send_tick(4'b0100);
            send_tick(4'b0000);
            write_reg(fkp_pkg::REG_DEBOUNCE, 16'hFFFF);
            send_tick(4'b0010);
            send_tick(4'b0010);
            write_reg(fkp_pkg::REG_DEBOUNCE, 16'd2);
            send_tick(4'b0000);
        end
    endtask

    // One press of a random key: latch, hold for a random span with noise on
    // the other keys, then release. Short holds give releases in debounce.
    task automatic send_press(input int deb, input int lng);
        logic [3:0] lv;
        int         k;
        int         hold_len;
        int         rel_len;
        int         i;
        begin
            k        = $urandom_range(0, 3);
            hold_len = $urandom_range(0, deb + lng + 3);
            rel_len  = $urandom_range(1, deb + 2);
            lv       = 4'($urandom);
            lv[k]    = 1'b1;
            lv       = lv & ~((4'd1 << k) - 4'd1);
            send_tick(lv);
            for (i = 0; i < hold_len; i++)
            begin
                lv    = 4'($urandom);
                lv[k] = 1'b1;
                send_tick(lv);
            end
            for (i = 0; i < rel_len; i++)
            begin
                lv = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0;
                lv[k] = 1'b0;
                send_tick(lv);
            end
        end
    endtask

    task automatic test_random_presses;
        int round;
        int deb;
        int lng;
        int start;
        int i;
        int n;
        begin
            for (round = 0; round < 4; round++)
            begin
                if (round == 0)
                begin
                    deb = 1;
                    lng = 1;
                end
                else if (round == 2)
                begin
                    deb = 0;
                    lng = $urandom_range(0, 3);
                end
                else
                begin
                    deb = $urandom_range(1, 6);
                    lng = $urandom_range(1, 12);
                end
                write_reg(fkp_pkg::REG_DEBOUNCE, 16'(deb));
                write_reg(fkp_pkg::REG_LONG, 16'(lng));
                start = ticks_sent;
                while (ticks_sent - start < 150)
                begin
                    if ($urandom_range(0, 99) < 20)
                    begin
                        // Noise: fully random levels.
                        n = $urandom_range(1, 4);
                        for (i = 0; i < n; i++)
                            send_tick(4'($urandom));
                    end
                    else
                        send_press(deb, lng);
                end
            end
        end
    endtask

    // Hold the receiver off long enough to fill the block and stall input,
    // then run a stretch with no idling on either side.
    task automatic test_output_backpressure;
        int i;
        int start;
        begin
            write_reg(fkp_pkg::REG_DEBOUNCE, 16'd2);
            write_reg(fkp_pkg::REG_LONG, 16'd3);
            hold_off_left = 300;
            for (i = 0; i < 6; i++)
                send_press(2, 3);
            steady = 1'b1;
            start = ticks_sent;
            while (ticks_sent - start < 100)
                send_press(2, 3);
            steady = 1'b0;
        end
    endtask

    // Receiver: check each taken beat against the oldest prediction, then
    // choose the stall for the next cycle.
    always @(posedge clk)
    begin
        fkp_pkg::result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("output beat with no prediction waiting: mode_bits %h", mode_bits);
                fail_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (mode_bits !== exp_r.mode_bits)
                begin
                    $error("mode_bits expected %h actual %h", exp_r.mode_bits, mode_bits);
                    fail_count++;
                end
                if (press_kind !== exp_r.press_kind)
                begin
                    $error("press_kind expected %0d actual %0d", exp_r.press_kind, press_kind);
                    fail_count++;
                end
                if (press_key !== exp_r.press_key)
                begin
                    $error("press_key expected %0d actual %0d", exp_r.press_key, press_key);
                    fail_count++;
                end
            end
        end
        if (hold_off_left > 0)
        begin
            out_stall <= 1'b1;
            hold_off_left--;
        end
        else if (steady)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < 17);
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_each_key();
        test_zero_thresholds();
        test_max_thresholds();
        test_random_presses();
        test_output_backpressure();
        // Drain the last beats and give the output stage time to show any
        // stray beat.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
